### design/ast_pkg.sv
// Shared types, character constants and helper functions for the source tokenizer.
`default_nettype none
package ast_pkg;

    // Width of the line and column counters.
    localparam int unsigned POSITION_BITS = 16;
    // Width of the reported start positions.
    localparam int unsigned OUT_POS_BITS = 16;

    // Characters the scanner reacts to.
    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_DQUOTE = 8'h22;
    localparam logic [7:0] CH_HASH   = 8'h23;
    localparam logic [7:0] CH_SQUOTE = 8'h27;
    localparam logic [7:0] CH_DOT    = 8'h2E;
    localparam logic [7:0] CH_COLON  = 8'h3A;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_UNDER  = 8'h5F;
    localparam logic [7:0] CH_LOW_N  = 8'h6E;
    localparam logic [7:0] CH_LOW_R  = 8'h72;
    localparam logic [7:0] CH_LOW_T  = 8'h74;

    // Token kinds as reported on the result channel.
    typedef enum logic [2:0] {
        KIND_EOL    = 3'd0,
        KIND_IDENT  = 3'd1,
        KIND_STRING = 3'd2,
        KIND_CHAR   = 3'd3,
        KIND_SYMBOL = 3'd4,
        KIND_EOF    = 3'd5,
        KIND_ERROR  = 3'd6
    } t_kind;

    // Error codes carried by error results.
    typedef enum logic [1:0] {
        ERR_NONE         = 2'd0,
        ERR_UNTERM_STR   = 2'd1,
        ERR_UNTERM_CHAR  = 2'd2,
        ERR_MISSING_QUOTE = 2'd3
    } t_err;

    // Scanner modes.
    typedef enum logic [2:0] {
        MODE_IDLE      = 3'd0,
        MODE_COMMENT   = 3'd1,
        MODE_IDENT     = 3'd2,
        MODE_STR       = 3'd3,
        MODE_STR_ESC   = 3'd4,
        MODE_CHR       = 3'd5,
        MODE_CHR_ESC   = 3'd6,
        MODE_CHR_CLOSE = 3'd7
    } t_mode;

    // One result item, without the end-of-run flag.
    typedef struct packed {
        t_kind                   kind;
        logic [7:0]              text_byte;
        logic                    has_byte;
        logic                    token_end;
        logic [OUT_POS_BITS-1:0] start_line;
        logic [OUT_POS_BITS-1:0] start_column;
        t_err                    error_code;
    } t_result;

    // All results caused by one source byte: one or two.
    typedef struct packed {
        t_result first;
        t_result second;
        logic    two;
    } t_entry;

    function automatic logic is_alpha(input logic [7:0] c);
        return (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A);
    endfunction

    function automatic logic is_ident_head(input logic [7:0] c);
        return is_alpha(c) || c == CH_UNDER || c == CH_DOT;
    endfunction

    function automatic logic is_ident_tail(input logic [7:0] c);
        return is_ident_head(c) || (c >= 8'h30 && c <= 8'h39) || c == CH_COLON;
    endfunction

    function automatic logic [7:0] unescape(input logic [7:0] c);
        logic [7:0] r;
        r = c;
        if (c == CH_LOW_N) r = CH_LF;
        else if (c == CH_LOW_T) r = CH_TAB;
        else if (c == CH_LOW_R) r = CH_CR;
        return r;
    endfunction

    function automatic t_result make_result(input t_kind k, input logic [7:0] b,
                                            input logic has, input logic fin,
                                            input logic [OUT_POS_BITS-1:0] ln,
                                            input logic [OUT_POS_BITS-1:0] col,
                                            input t_err err);
        t_result r;
        r.kind         = k;
        r.text_byte    = has ? b : 8'h00;
        r.has_byte     = has;
        r.token_end    = fin;
        r.start_line   = ln;
        r.start_column = col;
        r.error_code   = err;
        return r;
    endfunction

endpackage
`default_nettype wire

### design/assembly_source_tokenizer.sv
// Top level of the assembly source tokenizer: input register, scanner and result queue.
//
// Input channel: one source byte per transaction (i_in_valid / o_in_ready); byte 0 marks
// end of input. Output channel: one result per transaction (o_out_valid / i_out_ready);
// a source byte causes zero, one or two results, and o_last_of_run marks the last one.
// The accepted byte sits in an input register; when the result queue has room, the
// scanner updates its state and writes that byte's results as one entry into a
// two-entry result queue, from which the results are offered.
// Bytes are taken at one byte per cycle while the receiver keeps up; a byte that ends an
// identifier and starts another token yields two results, which leave one at a time, so
// the rate is then set by the single-result output port draining the queue.
// When the receiver stalls, the queue fills and then the input register holds its byte
// and o_in_ready drops; nothing is lost.
// Reset (synchronous, active low) empties the queue and input register, returns the
// scanner to idle at line 1, column 1, and clears the halt left by an error result.
`default_nettype none
module assembly_source_tokenizer #(
    parameter int unsigned POSITION_BITS = ast_pkg::POSITION_BITS
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_ready,
    input  wire logic [7:0]  i_source_byte,
    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output logic [2:0]       o_token_kind,
    output logic [7:0]       o_text_byte,
    output logic             o_has_byte,
    output logic             o_token_end,
    output logic [15:0]      o_start_line,
    output logic [15:0]      o_start_column,
    output logic [1:0]       o_error_code,
    output logic             o_last_of_run
);

    logic             r_in_valid;
    logic [7:0]       r_in_byte;
    logic             fire, can_push, push;
    ast_pkg::t_entry  entry;
    ast_pkg::t_result res;

    assign fire       = r_in_valid && can_push;
    assign o_in_ready = !r_in_valid || fire;

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) r_in_byte <= i_source_byte;
    end

    ast_scan #(
        .POSITION_BITS(POSITION_BITS)
    ) u_scan (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fire  (fire),
        .i_byte  (r_in_byte),
        .o_push  (push),
        .o_entry (entry)
    );

    ast_rqueue u_rqueue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .i_entry    (entry),
        .o_can_push (can_push),
        .o_valid    (o_out_valid),
        .i_ready    (i_out_ready),
        .o_result   (res),
        .o_last     (o_last_of_run)
    );

    // Result fields onto the ports.
    assign o_token_kind   = res.kind;
    assign o_text_byte    = res.text_byte;
    assign o_has_byte     = res.has_byte;
    assign o_token_end    = res.token_end;
    assign o_start_line   = res.start_line;
    assign o_start_column = res.start_column;
    assign o_error_code   = res.error_code;

endmodule
`default_nettype wire

### design/ast_scan.sv
// Scanner state and per-byte token logic: one registered byte in, up to two results out.
`default_nettype none
module ast_scan #(
    parameter int unsigned POSITION_BITS = ast_pkg::POSITION_BITS
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_fire,
    input  wire logic [7:0]    i_byte,
    output logic               o_push,
    output ast_pkg::t_entry    o_entry
);

    localparam int unsigned OPB = ast_pkg::OUT_POS_BITS;
    localparam logic [POSITION_BITS-1:0] POS_ONE = POSITION_BITS'(1);

    // Scanner state.
    ast_pkg::t_mode             r_mode, n_mode;
    logic [POSITION_BITS-1:0]   r_line, n_line;
    logic [POSITION_BITS-1:0]   r_col, n_col;
    logic [POSITION_BITS-1:0]   r_tok_line, n_tok_line;
    logic [POSITION_BITS-1:0]   r_tok_col, n_tok_col;
    logic [7:0]                 r_held, n_held;
    logic                       r_halt, n_halt;

    // Start positions capped to the reported width.
    logic [OPB-1:0] cur_line_cap, cur_col_cap, tok_line_cap, tok_col_cap;

    // Idle-mode handling of the byte.
    logic            id_emit;
    ast_pkg::t_result id_res;
    ast_pkg::t_mode  id_mode;
    logic            id_cons;

    logic            do_cons;
    logic [1:0]      cnt;
    ast_pkg::t_result res0, res1;

    function automatic logic [OPB-1:0] cap_pos(input logic [POSITION_BITS-1:0] v);
        logic [32:0] w;
        w = 33'(v);
        return (w > 33'(16'hFFFF)) ? {OPB{1'b1}} : w[OPB-1:0];
    endfunction

    assign cur_line_cap = cap_pos(r_line);
    assign cur_col_cap  = cap_pos(r_col);
    assign tok_line_cap = cap_pos(r_tok_line);
    assign tok_col_cap  = cap_pos(r_tok_col);

    // What the byte does when it arrives between tokens; the token starts here.
    always_comb begin
        id_emit = 1'b0;
        id_mode = ast_pkg::MODE_IDLE;
        id_cons = 1'b1;
        id_res  = ast_pkg::make_result(ast_pkg::KIND_SYMBOL, i_byte, 1'b1, 1'b1,
                                       cur_line_cap, cur_col_cap, ast_pkg::ERR_NONE);
        if (i_byte == ast_pkg::CH_NUL) begin
            id_cons = 1'b0;
            id_emit = 1'b1;
            id_res  = ast_pkg::make_result(ast_pkg::KIND_EOF, 8'h00, 1'b0, 1'b1,
                                           cur_line_cap, cur_col_cap, ast_pkg::ERR_NONE);
        end else if (i_byte == ast_pkg::CH_SPACE || i_byte == ast_pkg::CH_TAB ||
                     i_byte == ast_pkg::CH_CR) begin
            id_emit = 1'b0;
        end else if (i_byte == ast_pkg::CH_HASH) begin
            id_mode = ast_pkg::MODE_COMMENT;
        end else if (i_byte == ast_pkg::CH_LF) begin
            id_emit = 1'b1;
            id_res  = ast_pkg::make_result(ast_pkg::KIND_EOL, ast_pkg::CH_LF, 1'b1, 1'b1,
                                           cur_line_cap, cur_col_cap, ast_pkg::ERR_NONE);
        end else if (ast_pkg::is_ident_head(i_byte)) begin
            id_emit = 1'b1;
            id_mode = ast_pkg::MODE_IDENT;
            id_res  = ast_pkg::make_result(ast_pkg::KIND_IDENT, i_byte, 1'b1, 1'b0,
                                           cur_line_cap, cur_col_cap, ast_pkg::ERR_NONE);
        end else if (i_byte == ast_pkg::CH_DQUOTE) begin
            id_mode = ast_pkg::MODE_STR;
        end else if (i_byte == ast_pkg::CH_SQUOTE) begin
            id_mode = ast_pkg::MODE_CHR;
        end else begin
            id_emit = 1'b1;
        end
    end

    // Mode transitions and result selection for the current mode.
    always_comb begin
        n_mode     = r_mode;
        n_tok_line = r_tok_line;
        n_tok_col  = r_tok_col;
        n_held     = r_held;
        n_halt     = r_halt;
        do_cons    = 1'b0;
        cnt        = 2'd0;
        res0       = id_res;
        res1       = id_res;

        if (!r_halt) begin
            case (r_mode)
                ast_pkg::MODE_COMMENT: begin
                    if (i_byte == ast_pkg::CH_NUL) begin
                        n_mode     = id_mode;
                        n_tok_line = r_line;
                        n_tok_col  = r_col;
                        do_cons    = id_cons;
                        cnt        = {1'b0, id_emit};
                    end else begin
                        do_cons = 1'b1;
                        if (i_byte == ast_pkg::CH_LF) n_mode = ast_pkg::MODE_IDLE;
                    end
                end
                ast_pkg::MODE_IDENT: begin
                    if (i_byte != ast_pkg::CH_NUL && ast_pkg::is_ident_tail(i_byte)) begin
                        do_cons = 1'b1;
                        cnt     = 2'd1;
                        res0    = ast_pkg::make_result(ast_pkg::KIND_IDENT, i_byte, 1'b1,
                                      1'b0, tok_line_cap, tok_col_cap, ast_pkg::ERR_NONE);
                    end else begin
                        // Close the identifier, then treat the byte as a fresh start.
                        res0       = ast_pkg::make_result(ast_pkg::KIND_IDENT, 8'h00, 1'b0,
                                         1'b1, tok_line_cap, tok_col_cap, ast_pkg::ERR_NONE);
                        res1       = id_res;
                        cnt        = id_emit ? 2'd2 : 2'd1;
                        n_mode     = id_mode;
                        n_tok_line = r_line;
                        n_tok_col  = r_col;
                        do_cons    = id_cons;
                    end
                end
                ast_pkg::MODE_STR: begin
                    if (i_byte == ast_pkg::CH_NUL || i_byte == ast_pkg::CH_LF) begin
                        cnt    = 2'd1;
                        res0   = ast_pkg::make_result(ast_pkg::KIND_ERROR, 8'h00, 1'b0, 1'b1,
                                     tok_line_cap, tok_col_cap, ast_pkg::ERR_UNTERM_STR);
                        n_halt = 1'b1;
                        n_mode = ast_pkg::MODE_IDLE;
                    end else begin
                        do_cons = 1'b1;
                        if (i_byte == ast_pkg::CH_DQUOTE) begin
                            cnt    = 2'd1;
                            res0   = ast_pkg::make_result(ast_pkg::KIND_STRING, 8'h00, 1'b0,
                                         1'b1, tok_line_cap, tok_col_cap, ast_pkg::ERR_NONE);
                            n_mode = ast_pkg::MODE_IDLE;
                        end else if (i_byte == ast_pkg::CH_BSLASH) begin
                            n_mode = ast_pkg::MODE_STR_ESC;
                        end else begin
                            cnt  = 2'd1;
                            res0 = ast_pkg::make_result(ast_pkg::KIND_STRING, i_byte, 1'b1,
                                       1'b0, tok_line_cap, tok_col_cap, ast_pkg::ERR_NONE);
                        end
                    end
                end
                ast_pkg::MODE_STR_ESC: begin
                    if (i_byte == ast_pkg::CH_NUL) begin
                        cnt    = 2'd1;
                        res0   = ast_pkg::make_result(ast_pkg::KIND_ERROR, 8'h00, 1'b0, 1'b1,
                                     tok_line_cap, tok_col_cap, ast_pkg::ERR_UNTERM_STR);
                        n_halt = 1'b1;
                        n_mode = ast_pkg::MODE_IDLE;
                    end else begin
                        do_cons = 1'b1;
                        cnt     = 2'd1;
                        res0    = ast_pkg::make_result(ast_pkg::KIND_STRING,
                                      ast_pkg::unescape(i_byte), 1'b1, 1'b0,
                                      tok_line_cap, tok_col_cap, ast_pkg::ERR_NONE);
                        n_mode  = ast_pkg::MODE_STR;
                    end
                end
                ast_pkg::MODE_CHR: begin
                    if (i_byte == ast_pkg::CH_NUL || i_byte == ast_pkg::CH_LF) begin
                        cnt    = 2'd1;
                        res0   = ast_pkg::make_result(ast_pkg::KIND_ERROR, 8'h00, 1'b0, 1'b1,
                                     tok_line_cap, tok_col_cap, ast_pkg::ERR_UNTERM_CHAR);
                        n_halt = 1'b1;
                        n_mode = ast_pkg::MODE_IDLE;
                    end else begin
                        do_cons = 1'b1;
                        if (i_byte == ast_pkg::CH_BSLASH) begin
                            n_mode = ast_pkg::MODE_CHR_ESC;
                        end else begin
                            n_held = i_byte;
                            n_mode = ast_pkg::MODE_CHR_CLOSE;
                        end
                    end
                end
                ast_pkg::MODE_CHR_ESC: begin
                    if (i_byte == ast_pkg::CH_NUL) begin
                        cnt    = 2'd1;
                        res0   = ast_pkg::make_result(ast_pkg::KIND_ERROR, 8'h00, 1'b0, 1'b1,
                                     tok_line_cap, tok_col_cap, ast_pkg::ERR_MISSING_QUOTE);
                        n_halt = 1'b1;
                        n_mode = ast_pkg::MODE_IDLE;
                    end else begin
                        do_cons = 1'b1;
                        n_held  = ast_pkg::unescape(i_byte);
                        n_mode  = ast_pkg::MODE_CHR_CLOSE;
                    end
                end
                ast_pkg::MODE_CHR_CLOSE: begin
                    if (i_byte == ast_pkg::CH_SQUOTE) begin
                        do_cons = 1'b1;
                        cnt     = 2'd1;
                        res0    = ast_pkg::make_result(ast_pkg::KIND_CHAR, r_held, 1'b1, 1'b1,
                                      tok_line_cap, tok_col_cap, ast_pkg::ERR_NONE);
                        n_mode  = ast_pkg::MODE_IDLE;
                    end else begin
                        cnt    = 2'd1;
                        res0   = ast_pkg::make_result(ast_pkg::KIND_ERROR, 8'h00, 1'b0, 1'b1,
                                     tok_line_cap, tok_col_cap, ast_pkg::ERR_MISSING_QUOTE);
                        n_halt = 1'b1;
                        n_mode = ast_pkg::MODE_IDLE;
                    end
                end
                default: begin
                    n_mode     = id_mode;
                    n_tok_line = r_line;
                    n_tok_col  = r_col;
                    do_cons    = id_cons;
                    cnt        = {1'b0, id_emit};
                end
            endcase
        end
    end

    // Position advance with saturating counters.
    always_comb begin
        n_line = r_line;
        n_col  = r_col;
        if (do_cons) begin
            if (i_byte == ast_pkg::CH_LF) begin
                if (!(&r_line)) n_line = r_line + POS_ONE;
                n_col = POS_ONE;
            end else if (!(&r_col)) begin
                n_col = r_col + POS_ONE;
            end
        end
    end

    assign o_push         = i_fire && (cnt != 2'd0);
    assign o_entry.first  = res0;
    assign o_entry.second = res1;
    assign o_entry.two    = (cnt == 2'd2);

    // State registers advance only on a processed byte.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode     <= ast_pkg::MODE_IDLE;
            r_line     <= POS_ONE;
            r_col      <= POS_ONE;
            r_tok_line <= POS_ONE;
            r_tok_col  <= POS_ONE;
            r_held     <= 8'h00;
            r_halt     <= 1'b0;
        end else if (i_fire) begin
            r_mode     <= n_mode;
            r_line     <= n_line;
            r_col      <= n_col;
            r_tok_line <= n_tok_line;
            r_tok_col  <= n_tok_col;
            r_held     <= n_held;
            r_halt     <= n_halt;
        end
    end

endmodule
`default_nettype wire

### design/ast_rqueue.sv
// Two-entry result queue; each entry holds the one or two results of one source byte.
`default_nettype none
module ast_rqueue (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_push,
    input  wire ast_pkg::t_entry i_entry,
    output logic             o_can_push,
    output logic             o_valid,
    input  wire logic        i_ready,
    output ast_pkg::t_result o_result,
    output logic             o_last
);

    ast_pkg::t_entry r_q [2];
    logic            r_wp, r_rp, r_sub;
    logic [1:0]      r_cnt, n_cnt;
    logic            pop, take;
    ast_pkg::t_entry head;

    assign head       = r_q[r_rp];
    assign o_valid    = (r_cnt != 2'd0);
    assign o_last     = !head.two || r_sub;
    assign o_result   = r_sub ? head.second : head.first;
    assign take       = o_valid && i_ready;
    assign pop        = take && o_last;
    assign o_can_push = (r_cnt != 2'd2) || pop;

    always_comb begin
        n_cnt = r_cnt;
        if (i_push && !pop) n_cnt = r_cnt + 2'd1;
        else if (!i_push && pop) n_cnt = r_cnt - 2'd1;
    end

    // Entry storage.
    always_ff @(posedge i_clk) begin
        if (i_push) r_q[r_wp] <= i_entry;
    end

    // Pointers, fill count and position within the head entry.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_sub <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            r_cnt <= n_cnt;
            if (i_push) r_wp <= !r_wp;
            if (pop) begin
                r_rp  <= !r_rp;
                r_sub <= 1'b0;
            end else if (take) begin
                r_sub <= 1'b1;
            end
        end
    end

endmodule
`default_nettype wire

### tb/tb_assembly_source_tokenizer.sv
// Self-checking testbench for the assembly source tokenizer with a built-in token predictor.
`timescale 1ns / 100ps
module tb_assembly_source_tokenizer;

    localparam int PB = ast_pkg::POSITION_BITS;
    localparam logic [PB-1:0] POS_TOP = '1;
    localparam logic [PB-1:0] POS_ONE = PB'(1);
    localparam int RANDOM_ITEMS = 900;
    localparam int HOLD_CYCLES = 300;
    localparam int DRAIN_CYCLES = 20;

    // One expected result as it should appear on the output ports.
    typedef struct packed {
        ast_pkg::t_kind kind;
        logic [7:0]     text;
        logic           has_byte;
        logic           token_end;
        logic [15:0]    line;
        logic [15:0]    column;
        ast_pkg::t_err  err;
        logic           last;
    } t_tok_result;

    // One row of the directed table; pinned rows carry their result typed in.
    typedef struct packed {
        logic [7:0]  src;
        logic        pinned;
        t_tok_result want;
    } t_stim_row;

    // Ways to break the scanner at the end of the run.
    typedef enum int {
        BAD_STR_NEWLINE,
        BAD_STR_EOF,
        BAD_STR_ESC_EOF,
        BAD_CHR_OPEN,
        BAD_CHR_ESC_EOF,
        BAD_CHR_CLOSE
    } t_bad_tail;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_ready;
    logic [7:0]  i_source_byte;
    logic        o_out_valid;
    logic        i_out_ready;
    logic [2:0]  o_token_kind;
    logic [7:0]  o_text_byte;
    logic        o_has_byte;
    logic        o_token_end;
    logic [15:0] o_start_line;
    logic [15:0] o_start_column;
    logic [1:0]  o_error_code;
    logic        o_last_of_run;

    assembly_source_tokenizer dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_source_byte  (i_source_byte),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_token_kind   (o_token_kind),
        .o_text_byte    (o_text_byte),
        .o_has_byte     (o_has_byte),
        .o_token_end    (o_token_end),
        .o_start_line   (o_start_line),
        .o_start_column (o_start_column),
        .o_error_code   (o_error_code),
        .o_last_of_run  (o_last_of_run)
    );

    // Predicted scanner state.
    ast_pkg::t_mode scan_mode;
    logic [PB-1:0]  cur_line;
    logic [PB-1:0]  cur_col;
    logic [PB-1:0]  tok_line;
    logic [PB-1:0]  tok_col;
    logic [7:0]     held_byte;
    logic           stopped;
    t_tok_result    step_buf [0:1];
    int             step_n;

    t_tok_result expected_tokens [$];
    t_stim_row   directed_rows [$];

    int  errors = 0;
    int  results_seen = 0;
    int  bytes_sent = 0;
    int  source_calm = 0;
    int  sink_calm = 0;
    bit  hold_due = 0;

    // Clock generation.
    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // Run limit.
    initial begin
        #20_000_000;
        $display("FAIL assembly_source_tokenizer");
        $finish;
    end

    function automatic bit is_blank(input logic [7:0] c);
        return c == ast_pkg::CH_SPACE || c == ast_pkg::CH_TAB || c == ast_pkg::CH_CR;
    endfunction

    function automatic bit starts_name(input logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == ast_pkg::CH_UNDER
            || c == ast_pkg::CH_DOT;
    endfunction

    function automatic bit continues_name(input logic [7:0] c);
        return starts_name(c) || (c >= "0" && c <= "9") || c == ast_pkg::CH_COLON;
    endfunction

    function automatic bit is_symbol(input logic [7:0] c);
        return !(starts_name(c) || is_blank(c) || c == ast_pkg::CH_NUL || c == ast_pkg::CH_LF
            || c == ast_pkg::CH_HASH || c == ast_pkg::CH_DQUOTE || c == ast_pkg::CH_SQUOTE);
    endfunction

    function automatic logic [7:0] decode_escape(input logic [7:0] c);
        case (c)
            ast_pkg::CH_LOW_N: return ast_pkg::CH_LF;
            ast_pkg::CH_LOW_T: return ast_pkg::CH_TAB;
            ast_pkg::CH_LOW_R: return ast_pkg::CH_CR;
            default:           return c;
        endcase
    endfunction

    function automatic logic [15:0] cap_pos(input logic [PB-1:0] v);
        return (v > 16'hFFFF) ? 16'hFFFF : 16'(v);
    endfunction

    function automatic logic [7:0] rand_byte(input int lo, input int hi);
        return 8'($urandom_range(lo, hi));
    endfunction

    // Gap before the next transaction, with occasional runs of back-to-back traffic.
    function automatic int draw_gap(inout int calm_left);
        if (calm_left > 0) begin
            calm_left--;
            return 0;
        end
        if ($urandom_range(0, 39) == 0) calm_left = $urandom_range(10, 40);
        return $urandom_range(0, 15);
    endfunction

    // Position update for a consumed byte; both counters stick at their maximum.
    task automatic advance(input logic [7:0] c);
        if (c == ast_pkg::CH_LF) begin
            if (cur_line != POS_TOP) cur_line++;
            cur_col = POS_ONE;
        end else if (cur_col != POS_TOP) begin
            cur_col++;
        end
    endtask

    task automatic note(input ast_pkg::t_kind k, input logic [7:0] b, input logic has,
                        input logic fin, input ast_pkg::t_err e);
        t_tok_result r;
        r.kind      = k;
        r.text      = has ? b : 8'h00;
        r.has_byte  = has;
        r.token_end = fin;
        r.line      = cap_pos(tok_line);
        r.column    = cap_pos(tok_col);
        r.err       = e;
        r.last      = 1'b0;
        step_buf[step_n] = r;
        step_n++;
    endtask

    task automatic abort_token(input ast_pkg::t_err e);
        note(ast_pkg::KIND_ERROR, 8'h00, 1'b0, 1'b1, e);
        stopped   = 1'b1;
        scan_mode = ast_pkg::MODE_IDLE;
    endtask

    // A byte seen between tokens: it opens a token, gets skipped or ends the input.
    task automatic begin_token(input logic [7:0] c);
        tok_line  = cur_line;
        tok_col   = cur_col;
        scan_mode = ast_pkg::MODE_IDLE;
        if (c == ast_pkg::CH_NUL) begin
            note(ast_pkg::KIND_EOF, 8'h00, 1'b0, 1'b1, ast_pkg::ERR_NONE);
        end else begin
            advance(c);
            if (c == ast_pkg::CH_HASH) begin
                scan_mode = ast_pkg::MODE_COMMENT;
            end else if (c == ast_pkg::CH_LF) begin
                note(ast_pkg::KIND_EOL, ast_pkg::CH_LF, 1'b1, 1'b1, ast_pkg::ERR_NONE);
            end else if (starts_name(c)) begin
                note(ast_pkg::KIND_IDENT, c, 1'b1, 1'b0, ast_pkg::ERR_NONE);
                scan_mode = ast_pkg::MODE_IDENT;
            end else if (c == ast_pkg::CH_DQUOTE) begin
                scan_mode = ast_pkg::MODE_STR;
            end else if (c == ast_pkg::CH_SQUOTE) begin
                scan_mode = ast_pkg::MODE_CHR;
            end else if (!is_blank(c)) begin
                note(ast_pkg::KIND_SYMBOL, c, 1'b1, 1'b1, ast_pkg::ERR_NONE);
            end
        end
    endtask

    // Advance the predicted scanner by one accepted byte and queue what it yields.
    task automatic tokenize_byte(input logic [7:0] c, input bit record);
        t_tok_result r;
        step_n = 0;
        if (!stopped) begin
            case (scan_mode)
                ast_pkg::MODE_COMMENT: begin
                    if (c == ast_pkg::CH_NUL) begin
                        begin_token(c);
                    end else begin
                        advance(c);
                        if (c == ast_pkg::CH_LF) scan_mode = ast_pkg::MODE_IDLE;
                    end
                end
                ast_pkg::MODE_IDENT: begin
                    if (c != ast_pkg::CH_NUL && continues_name(c)) begin
                        advance(c);
                        note(ast_pkg::KIND_IDENT, c, 1'b1, 1'b0, ast_pkg::ERR_NONE);
                    end else begin
                        note(ast_pkg::KIND_IDENT, 8'h00, 1'b0, 1'b1, ast_pkg::ERR_NONE);
                        begin_token(c);
                    end
                end
                ast_pkg::MODE_STR: begin
                    if (c == ast_pkg::CH_NUL || c == ast_pkg::CH_LF) begin
                        abort_token(ast_pkg::ERR_UNTERM_STR);
                    end else begin
                        advance(c);
                        if (c == ast_pkg::CH_DQUOTE) begin
                            note(ast_pkg::KIND_STRING, 8'h00, 1'b0, 1'b1, ast_pkg::ERR_NONE);
                            scan_mode = ast_pkg::MODE_IDLE;
                        end else if (c == ast_pkg::CH_BSLASH) begin
                            scan_mode = ast_pkg::MODE_STR_ESC;
                        end else begin
                            note(ast_pkg::KIND_STRING, c, 1'b1, 1'b0, ast_pkg::ERR_NONE);
                        end
                    end
                end
                ast_pkg::MODE_STR_ESC: begin
                    if (c == ast_pkg::CH_NUL) begin
                        abort_token(ast_pkg::ERR_UNTERM_STR);
                    end else begin
                        advance(c);
                        note(ast_pkg::KIND_STRING, decode_escape(c), 1'b1, 1'b0,
                             ast_pkg::ERR_NONE);
                        scan_mode = ast_pkg::MODE_STR;
                    end
                end
                ast_pkg::MODE_CHR: begin
                    if (c == ast_pkg::CH_NUL || c == ast_pkg::CH_LF) begin
                        abort_token(ast_pkg::ERR_UNTERM_CHAR);
                    end else begin
                        advance(c);
                        if (c == ast_pkg::CH_BSLASH) begin
                            scan_mode = ast_pkg::MODE_CHR_ESC;
                        end else begin
                            held_byte = c;
                            scan_mode = ast_pkg::MODE_CHR_CLOSE;
                        end
                    end
                end
                ast_pkg::MODE_CHR_ESC: begin
                    if (c == ast_pkg::CH_NUL) begin
                        abort_token(ast_pkg::ERR_MISSING_QUOTE);
                    end else begin
                        advance(c);
                        held_byte = decode_escape(c);
                        scan_mode = ast_pkg::MODE_CHR_CLOSE;
                    end
                end
                ast_pkg::MODE_CHR_CLOSE: begin
                    if (c == ast_pkg::CH_SQUOTE) begin
                        advance(c);
                        note(ast_pkg::KIND_CHAR, held_byte, 1'b1, 1'b1, ast_pkg::ERR_NONE);
                        scan_mode = ast_pkg::MODE_IDLE;
                    end else begin
                        abort_token(ast_pkg::ERR_MISSING_QUOTE);
                    end
                end
                default: begin_token(c);
            endcase
        end
        if (record) begin
            for (int i = 0; i < step_n; i++) begin
                r = step_buf[i];
                r.last = (i == step_n - 1);
                expected_tokens.insert(expected_tokens.size(), r);
            end
        end
    endtask

    // Offer one source byte and wait for its transaction to complete.
    task automatic send_byte(input logic [7:0] b);
        int gap;
        gap = draw_gap(source_calm);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_source_byte <= b;
        do @(posedge i_clk); while (!o_in_ready);
        bytes_sent++;
    endtask

    task automatic feed(input logic [7:0] b);
        send_byte(b);
        tokenize_byte(b, 1'b1);
    endtask

    // Stop offering bytes until every predicted result has been drained.
    task automatic wait_drained();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (expected_tokens.size() != 0);
    endtask

    task automatic row(input logic [7:0] src);
        t_stim_row s;
        s = '0;
        s.src = src;
        directed_rows.insert(directed_rows.size(), s);
    endtask

    task automatic row_pinned(input logic [7:0] src, input ast_pkg::t_kind k,
                              input logic [7:0] text, input logic has, input logic fin,
                              input logic [15:0] ln, input logic [15:0] col);
        t_stim_row s;
        s.src    = src;
        s.pinned = 1'b1;
        s.want   = '{kind: k, text: text, has_byte: has, token_end: fin, line: ln,
                     column: col, err: ast_pkg::ERR_NONE, last: 1'b1};
        directed_rows.insert(directed_rows.size(), s);
    endtask

    // One well-formed piece of source text, or a little harmless noise.
    task automatic feed_segment();
        logic [7:0] b;
        int         pick;
        int         n;
        pick = $urandom_range(0, 99);
        if (pick < 25) begin
            // Identifier.
            do b = rand_byte(1, 255); while (!starts_name(b));
            feed(b);
            n = $urandom_range(0, 8);
            repeat (n) begin
                do b = rand_byte(1, 255); while (!continues_name(b));
                feed(b);
            end
        end else if (pick < 40) begin
            // String with plain bytes and escapes.
            feed(ast_pkg::CH_DQUOTE);
            n = $urandom_range(0, 10);
            repeat (n) begin
                if ($urandom_range(0, 3) == 0) begin
                    feed(ast_pkg::CH_BSLASH);
                    b = rand_byte(1, 255);
                    case ($urandom_range(0, 5))
                        0: b = ast_pkg::CH_LOW_N;
                        1: b = ast_pkg::CH_LOW_T;
                        2: b = ast_pkg::CH_LOW_R;
                        3: b = ast_pkg::CH_LF;
                        default: ;
                    endcase
                    feed(b);
                end else begin
                    do b = rand_byte(1, 255);
                    while (b == ast_pkg::CH_LF || b == ast_pkg::CH_DQUOTE ||
                           b == ast_pkg::CH_BSLASH);
                    feed(b);
                end
            end
            feed(ast_pkg::CH_DQUOTE);
        end else if (pick < 52) begin
            // Character literal, plain or escaped.
            feed(ast_pkg::CH_SQUOTE);
            if ($urandom_range(0, 2) == 0) begin
                feed(ast_pkg::CH_BSLASH);
                b = rand_byte(1, 255);
                case ($urandom_range(0, 4))
                    0: b = ast_pkg::CH_LOW_N;
                    1: b = ast_pkg::CH_LOW_T;
                    2: b = ast_pkg::CH_LOW_R;
                    default: ;
                endcase
                feed(b);
            end else begin
                do b = rand_byte(1, 255);
                while (b == ast_pkg::CH_LF || b == ast_pkg::CH_BSLASH);
                feed(b);
            end
            feed(ast_pkg::CH_SQUOTE);
        end else if (pick < 58) begin
            // Comment, closed by a newline or now and then by end of input.
            feed(ast_pkg::CH_HASH);
            n = $urandom_range(0, 8);
            repeat (n) begin
                do b = rand_byte(1, 255); while (b == ast_pkg::CH_LF);
                feed(b);
            end
            feed(($urandom_range(0, 4) == 0) ? ast_pkg::CH_NUL : ast_pkg::CH_LF);
        end else if (pick < 68) begin
            n = $urandom_range(1, 3);
            repeat (n) begin
                case ($urandom_range(0, 2))
                    0: feed(ast_pkg::CH_SPACE);
                    1: feed(ast_pkg::CH_TAB);
                    default: feed(ast_pkg::CH_CR);
                endcase
            end
        end else if (pick < 80) begin
            feed(ast_pkg::CH_LF);
        end else if (pick < 92) begin
            do b = rand_byte(1, 255); while (!is_symbol(b));
            feed(b);
        end else if (pick < 95) begin
            feed(ast_pkg::CH_NUL);
        end else begin
            // Noise that can neither open a quote nor hide later text in a comment.
            n = $urandom_range(1, 6);
            repeat (n) begin
                do b = rand_byte(0, 255);
                while (b == ast_pkg::CH_DQUOTE || b == ast_pkg::CH_SQUOTE ||
                       b == ast_pkg::CH_HASH);
                feed(b);
            end
        end
    endtask

    // Compare one accepted result with the oldest expectation.
    task automatic check_token();
        t_tok_result want;
        results_seen++;
        if (expected_tokens.size() == 0) begin
            $error("unexpected result: token_kind %0d text_byte %0h", o_token_kind,
                   o_text_byte);
            errors++;
        end else begin
            want = expected_tokens.pop_front();
            if (o_token_kind !== want.kind) begin
                $error("token_kind: expected %0d, got %0d", want.kind, o_token_kind);
                errors++;
            end
            if (o_text_byte !== want.text) begin
                $error("text_byte: expected %0h, got %0h", want.text, o_text_byte);
                errors++;
            end
            if (o_has_byte !== want.has_byte) begin
                $error("has_byte: expected %0d, got %0d", want.has_byte, o_has_byte);
                errors++;
            end
            if (o_token_end !== want.token_end) begin
                $error("token_end: expected %0d, got %0d", want.token_end, o_token_end);
                errors++;
            end
            if (o_start_line !== want.line) begin
                $error("start_line: expected %0d, got %0d", want.line, o_start_line);
                errors++;
            end
            if (o_start_column !== want.column) begin
                $error("start_column: expected %0d, got %0d", want.column, o_start_column);
                errors++;
            end
            if (o_error_code !== want.err) begin
                $error("error_code: expected %0d, got %0d", want.err, o_error_code);
                errors++;
            end
            if (o_last_of_run !== want.last) begin
                $error("last_of_run: expected %0d, got %0d", want.last, o_last_of_run);
                errors++;
            end
        end
    endtask

    // Result side: random stalls, one long hold-off on request, check every transaction.
    initial begin : result_sink
        int stall;
        i_out_ready <= 1'b0;
        do @(posedge i_clk); while (i_rst_n !== 1'b1);
        forever begin
            if (hold_due) begin
                hold_due = 1'b0;
                stall = HOLD_CYCLES;
            end else begin
                stall = draw_gap(sink_calm);
            end
            if (stall > 0) begin
                i_out_ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            i_out_ready <= 1'b1;
            do @(posedge i_clk); while (!o_out_valid);
            check_token();
        end
    end

    // Source side: directed table, random text, then a fatal error.
    initial begin : source_feed
        t_bad_tail  tail;
        logic [7:0] b;
        int         start_bytes;
        bit         hold_done;
        bit         pause_done;

        i_rst_n       = 1'b0;
        i_in_valid    = 1'b0;
        i_source_byte = 8'h00;
        scan_mode     = ast_pkg::MODE_IDLE;
        cur_line      = POS_ONE;
        cur_col       = POS_ONE;
        tok_line      = POS_ONE;
        tok_col       = POS_ONE;
        held_byte     = 8'h00;
        stopped       = 1'b0;
        hold_done     = 1'b0;
        pause_done    = 1'b0;

        // Directed table: extremes of the byte, each non-error token kind, escapes and comments.
        row_pinned(ast_pkg::CH_NUL, ast_pkg::KIND_EOF, 8'h00, 1'b0, 1'b1, 16'd1, 16'd1);
        row_pinned(ast_pkg::CH_UNDER, ast_pkg::KIND_IDENT, ast_pkg::CH_UNDER, 1'b1, 1'b0,
                   16'd1, 16'd1);
        row("A");
        row("9");
        row(ast_pkg::CH_COLON);
        row("~");
        row_pinned(8'hFF, ast_pkg::KIND_SYMBOL, 8'hFF, 1'b1, 1'b1, 16'd1, 16'd6);
        row_pinned(8'h80, ast_pkg::KIND_SYMBOL, 8'h80, 1'b1, 1'b1, 16'd1, 16'd7);
        row(ast_pkg::CH_TAB);
        row(ast_pkg::CH_CR);
        row(ast_pkg::CH_SPACE);
        row(ast_pkg::CH_DQUOTE);
        row(ast_pkg::CH_BSLASH);
        row(ast_pkg::CH_LOW_N);
        row(ast_pkg::CH_BSLASH);
        row(ast_pkg::CH_LF);
        row(ast_pkg::CH_DQUOTE);
        row(ast_pkg::CH_SQUOTE);
        row(ast_pkg::CH_BSLASH);
        row(ast_pkg::CH_LOW_T);
        row(ast_pkg::CH_SQUOTE);
        row(ast_pkg::CH_HASH);
        row(ast_pkg::CH_LF);
        row(ast_pkg::CH_LF);
        row(ast_pkg::CH_DOT);
        row(ast_pkg::CH_NUL);

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_rows[i]) begin
            send_byte(directed_rows[i].src);
            tokenize_byte(directed_rows[i].src, !directed_rows[i].pinned);
            if (directed_rows[i].pinned) begin
                expected_tokens.insert(expected_tokens.size(), directed_rows[i].want);
            end
        end

        // Random source text, with one long output stall and one full drain on the way.
        start_bytes = bytes_sent;
        while (bytes_sent - start_bytes < RANDOM_ITEMS) begin
            if (!hold_done && bytes_sent - start_bytes > 300) begin
                hold_done   = 1'b1;
                hold_due    = 1'b1;
                source_calm = 100;
            end
            if (!pause_done && bytes_sent - start_bytes > 600) begin
                pause_done = 1'b1;
                wait_drained();
            end
            feed_segment();
        end

        // Finish with one error; afterwards the scanner must stay silent.
        wait_drained();
        tail = t_bad_tail'($urandom_range(0, 5));
        case (tail)
            BAD_STR_NEWLINE: begin
                feed(ast_pkg::CH_DQUOTE);
                feed("a");
                feed(ast_pkg::CH_LF);
            end
            BAD_STR_EOF: begin
                feed(ast_pkg::CH_DQUOTE);
                feed(ast_pkg::CH_NUL);
            end
            BAD_STR_ESC_EOF: begin
                feed(ast_pkg::CH_DQUOTE);
                feed(ast_pkg::CH_BSLASH);
                feed(ast_pkg::CH_NUL);
            end
            BAD_CHR_OPEN: begin
                feed(ast_pkg::CH_SQUOTE);
                feed(($urandom_range(0, 1) == 0) ? ast_pkg::CH_LF : ast_pkg::CH_NUL);
            end
            BAD_CHR_ESC_EOF: begin
                feed(ast_pkg::CH_SQUOTE);
                feed(ast_pkg::CH_BSLASH);
                feed(ast_pkg::CH_NUL);
            end
            default: begin
                feed(ast_pkg::CH_SQUOTE);
                do b = rand_byte(1, 255);
                while (b == ast_pkg::CH_LF || b == ast_pkg::CH_BSLASH);
                feed(b);
                do b = rand_byte(0, 255); while (b == ast_pkg::CH_SQUOTE);
                feed(b);
            end
        endcase
        repeat (6) feed(rand_byte(0, 255));

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Checked %0d results from %0d source bytes, with one long output stall",
                 results_seen, bytes_sent);
        $display("and one full drain; the run ended on error case %s and stayed silent.",
                 tail.name());
        if (errors == 0 && expected_tokens.size() == 0) begin
            $display("PASS assembly_source_tokenizer");
        end else begin
            $display("FAIL assembly_source_tokenizer");
        end
        $finish;
    end

endmodule
